[sv/sdf_pkg.sv]
package sdf_pkg;

   // Length modes of the conversion; codes above the listed ones mean 64 bits
   localparam logic [2:0] MODE_INT       = 3'd0;
   localparam logic [2:0] MODE_CHAR      = 3'd1;
   localparam logic [2:0] MODE_SHORT     = 3'd2;
   localparam logic [2:0] MODE_LONG      = 3'd3;
   localparam logic [2:0] MODE_LONG_LONG = 3'd4;

   // Sign codes
   localparam logic [1:0] SIGN_NONE  = 2'd0;
   localparam logic [1:0] SIGN_MINUS = 2'd1;
   localparam logic [1:0] SIGN_PLUS  = 2'd2;
   localparam logic [1:0] SIGN_SPACE = 2'd3;

   localparam int unsigned VALUE_W = 64;
   localparam int unsigned BITCNT_W = 6;

   typedef struct packed {
      logic signed [63:0] value;
      logic [2:0]         length_mode;
      logic               plus_flag;
      logic               space_flag;
      logic               has_precision;
      logic [11:0]        precision;
   } req_type;

   typedef struct packed {
      logic [1:0]  sign_code;
      logic [11:0] zero_pad;
      logic [4:0]  digit_count;
      logic        digit_valid;
      logic [3:0]  digit;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_EMIT
   } state_type;

endpackage

[sv/signed_decimal_formatter.sv]
// Signed decimal formatter.
// Request channel (req_valid/req_ready/req_data) takes one signed integer
// conversion per item: raw 64-bit value, length mode, plus/space flags and an
// optional precision. Response channel (rsp_valid/rsp_ready/rsp_data) returns
// the decimal digits of the magnitude, one item per digit, most significant
// first; every item repeats the sign code, the precision zero count and the
// digit count, and the final one has last set. A zero value with precision
// zero gives a single item without a digit.
// One conversion is in flight at a time; req_ready is high only when idle.
// Per conversion: accept, then shift-and-add-3 conversion over all VALUE_W
// magnitude bits (one magnitude bit per cycle into the BCD shift register),
// then leading zero digits are stripped one per cycle, then the digits go out
// one per cycle while the receiver is ready. The BCD shift register is shared
// by conversion, stripping and output, so no new request is taken before the
// final item of the current conversion is taken.
// When the receiver stalls, the current digit item holds on rsp_data and the
// block waits. Synchronous reset returns to idle and drops any item in flight.
module signed_decimal_formatter #(
   parameter int MAX_DIGITS    = 20,
   parameter int MAX_PRECISION = 4095
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sdf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sdf_pkg::rsp_type rsp_data
);
   import sdf_pkg::*;

   localparam int BCD_W = 4 * MAX_DIGITS;
   localparam logic [16:0] MAX_PREC_V = 17'(MAX_PRECISION);
   localparam logic [4:0]  MAX_DIG_V  = 5'(MAX_DIGITS);
   localparam logic [BITCNT_W-1:0] LAST_BIT = BITCNT_W'(VALUE_W - 1);

   state_type state_ff, state_in;

   // Datapath registers
   logic [VALUE_W-1:0] mag_ff, mag_in;       // magnitude, shifted out MSB first
   logic [BCD_W-1:0]   bcd_ff, bcd_in;       // BCD digits, top digit is the next one out
   logic [BITCNT_W-1:0] bitcnt_ff, bitcnt_in;
   logic               ovf_ff, ovf_in;       // a digit fell off the top of the BCD register
   logic               nodig_ff, nodig_in;   // zero value with precision zero
   logic [1:0]         sign_ff, sign_in;
   logic               hasp_ff, hasp_in;
   logic [11:0]        prec_ff, prec_in;
   logic [11:0]        pad_ff, pad_in;
   logic [4:0]         nd_ff, nd_in;         // digit count of the run
   logic [4:0]         rem_ff, rem_in;       // digits still in the BCD register

   logic req_fire, rsp_fire;
   logic [3:0] top_digit;
   logic       rsp_last;
   logic       skip_more;

   // Request decode
   logic [VALUE_W-1:0] sext_value;
   logic               neg;
   logic [1:0]         sign_sel;

   // Conversion step
   logic [BCD_W-1:0] bcd_adj;

   // Precision zero count
   logic [4:0]  nd_sel;
   logic [11:0] pad_diff;
   logic [16:0] pad_wide;

   assign req_fire  = req_valid & req_ready;
   assign rsp_fire  = rsp_valid & rsp_ready;
   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   assign rsp_last  = nodig_ff | (rem_ff == 5'd1);
   // Keep stripping while the top digit is a leading zero; the last digit stays
   assign skip_more = !nodig_ff && !ovf_ff && (top_digit == 4'd0) && (rem_ff > 5'd1);

   // Cut to the selected width and sign-extend, then take sign and magnitude
   always_comb begin
      case (req_data.length_mode)
         MODE_INT:   sext_value = {{32{req_data.value[31]}}, req_data.value[31:0]};
         MODE_CHAR:  sext_value = {{56{req_data.value[7]}}, req_data.value[7:0]};
         MODE_SHORT: sext_value = {{48{req_data.value[15]}}, req_data.value[15:0]};
         default:    sext_value = req_data.value;
      endcase
      neg = sext_value[VALUE_W-1];
      if (neg) begin
         sign_sel = SIGN_MINUS;
      end else if (req_data.plus_flag) begin
         sign_sel = SIGN_PLUS;
      end else if (req_data.space_flag) begin
         sign_sel = SIGN_SPACE;
      end else begin
         sign_sel = SIGN_NONE;
      end
   end

   // Add 3 to every digit of 5 or more before the doubling shift
   always_comb begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   // Leading zeros asked for by the precision, saturated
   always_comb begin
      nd_sel   = nodig_ff ? 5'd0 : rem_ff;
      pad_diff = prec_ff - {7'd0, nd_sel};
      if (hasp_ff && (prec_ff > {7'd0, nd_sel})) begin
         pad_wide = {5'd0, pad_diff};
      end else begin
         pad_wide = 17'd0;
      end
      if (pad_wide > MAX_PREC_V) begin
         pad_wide = MAX_PREC_V;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (bitcnt_ff == LAST_BIT) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (!skip_more) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_fire && rsp_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake and response fields
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EMIT: rsp_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
      rsp_data.sign_code   = sign_ff;
      rsp_data.zero_pad    = pad_ff;
      rsp_data.digit_count = nd_ff;
      rsp_data.digit_valid = !nodig_ff;
      rsp_data.digit       = nodig_ff ? 4'd0 : top_digit;
      rsp_data.last        = rsp_last;
   end

   // Datapath next values
   always_comb begin
      mag_in    = mag_ff;
      bcd_in    = bcd_ff;
      bitcnt_in = bitcnt_ff;
      ovf_in    = ovf_ff;
      nodig_in  = nodig_ff;
      sign_in   = sign_ff;
      hasp_in   = hasp_ff;
      prec_in   = prec_ff;
      pad_in    = pad_ff;
      nd_in     = nd_ff;
      rem_in    = rem_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mag_in    = neg ? (~sext_value + 64'd1) : sext_value;
               bcd_in    = '0;
               bitcnt_in = '0;
               ovf_in    = 1'b0;
               nodig_in  = req_data.has_precision && (req_data.precision == 12'd0)
                           && (sext_value == 64'd0);
               sign_in   = sign_sel;
               hasp_in   = req_data.has_precision;
               prec_in   = req_data.precision;
            end
         end
         ST_CONV: begin
            // Double the BCD value and shift in the next magnitude bit
            {ovf_in, bcd_in} = {ovf_ff | bcd_adj[BCD_W-1], bcd_adj[BCD_W-2:0], mag_ff[VALUE_W-1]};
            mag_in    = {mag_ff[VALUE_W-2:0], 1'b0};
            bitcnt_in = bitcnt_ff + 1'b1;
            rem_in    = MAX_DIG_V;
         end
         ST_SKIP: begin
            if (skip_more) begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               rem_in = rem_ff - 5'd1;
            end else begin
               nd_in  = nd_sel;
               pad_in = pad_wide[11:0];
            end
         end
         ST_EMIT: begin
            // Advance to the next digit once this one is taken
            if (rsp_fire && !rsp_last) begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               rem_in = rem_ff - 5'd1;
            end
         end
         default: begin
            mag_in = mag_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      bcd_ff    <= bcd_in;
      bitcnt_ff <= bitcnt_in;
      ovf_ff    <= ovf_in;
      nodig_ff  <= nodig_in;
      sign_ff   <= sign_in;
      hasp_ff   <= hasp_in;
      prec_ff   <= prec_in;
      pad_ff    <= pad_in;
      nd_ff     <= nd_in;
      rem_ff    <= rem_in;
   end

endmodule
